[src/log2_log10_cubic_approx_assert.svh]
// assertion macros shared by the log2/log10 checker
`ifndef LOG2_LOG10_CUBIC_APPROX_ASSERT_SVH
`define LOG2_LOG10_CUBIC_APPROX_ASSERT_SVH

// same-cycle implication, masked during reset
`define L2L10_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, masked during reset
`define L2L10_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

// next-cycle implication that also holds through reset
`define L2L10_ASSERT_RST(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

[src/l2l10_pkg.sv]
// shared constants, types and helpers for the log2/log10 approximation
package l2l10_pkg;

  // output format
  localparam int OUT_WIDTH     = 25;
  localparam int FRAC_BITS_DEF = 16;

  // polynomial coefficients, Q3.24 rounded to nearest
  localparam int COEF_C3 = 20661073;
  localparam int COEF_C2 = -69097386;
  localparam int COEF_C1 = 101031894;
  localparam int COEF_C0 = -52579199;

  // log10(2) in Q0.30
  localparam int LOG10_2_Q30 = 323228497;
  localparam int LOG10_2_W   = 30;

  // fraction point of F and of the Horner terms
  localparam int Q = 24;

  // input classification codes
  typedef enum logic [1:0] {
    CLS_NORMAL  = 2'd0,
    CLS_ZERO    = 2'd1,
    CLS_SPECIAL = 2'd2
  } in_class_t;

  // leading zeros of a 23-bit mantissa, 23 when it is all zero
  function automatic logic [4:0] lead_zeros(input logic [22:0] m);
    logic [4:0] lz;
    lz = 5'd23;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) begin
        lz = 5'(22 - i);
      end
    end
    return lz;
  endfunction

endpackage

[src/log2_log10_cubic_approx.sv]
// log2 / log10 cubic approximation pipeline for IEEE single inputs
//
// Usage:
//   in_valid / in_stall carry one request: an IEEE single bit pattern whose
//   sign is ignored. out_valid / out_stall carry one result: log_value in
//   two's complement with FRAC_BITS fraction bits and an input class
//   (normal or subnormal, zero, infinity or NaN).
//   cfg_wr_en / cfg_wr_data write base_select: 0 gives log2, 1 gives log10.
//   Write it only while no request is in flight.
// Stages: a request passes through 10 register stages: decode, normalize,
//   three multiply / round-add pairs for the Horner steps, log10 scaling,
//   round and saturate. Every stage holds one request.
// Throughput: one request per cycle while in_stall is low.
// Stall: each stage moves when its successor is empty or moving, so bubbles
//   close up and in_stall rises only when all stages are full and the output
//   is stalled. A stalled output holds its payload.
// Reset: rst_n (synchronous, active low) empties the pipeline and clears
//   base_select to log2 mode.
module log2_log10_cubic_approx #(
  parameter int FRAC_BITS = l2l10_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [31:0]                         in_float_bits,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [l2l10_pkg::OUT_WIDTH-1:0] out_log_value,
  output logic [1:0]                          out_input_class,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data
);

  localparam int NS   = 10;
  localparam int Y_W  = 32;
  localparam int P_W  = Y_W + 25;
  localparam int Y3_W = 34;
  localparam int W_W  = Y3_W + l2l10_pkg::LOG10_2_W + 1;
  localparam int SH   = 54 - FRAC_BITS;
  localparam int OW   = l2l10_pkg::OUT_WIDTH;

  localparam logic signed [Y_W-1:0] C3_Y = Y_W'(l2l10_pkg::COEF_C3);
  localparam logic signed [Y_W-1:0] C2_Y = Y_W'(l2l10_pkg::COEF_C2);
  localparam logic signed [Y_W-1:0] C1_Y = Y_W'(l2l10_pkg::COEF_C1);
  localparam logic signed [Y_W-1:0] C0_Y = Y_W'(l2l10_pkg::COEF_C0);
  localparam logic signed [l2l10_pkg::LOG10_2_W:0] L10_S =
    (l2l10_pkg::LOG10_2_W + 1)'(l2l10_pkg::LOG10_2_Q30);
  localparam logic signed [P_W-1:0] P_HALF = P_W'(1) <<< (l2l10_pkg::Q - 1);
  localparam logic signed [W_W-1:0] W_HALF = W_W'(1) <<< (SH - 1);
  localparam logic signed [W_W-1:0] OUT_MAX = (W_W'(1) <<< (OW - 1)) - W_W'(1);
  localparam logic signed [W_W-1:0] OUT_MIN = -(W_W'(1) <<< (OW - 1));

  // handshake state
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] en;
  logic          base_select_r;

  // decode stage
  logic                 [7:0]  d_expf_r;
  logic                 [22:0] d_mant_r;
  logic                 [4:0]  d_lz_r;
  logic                 [4:0]  d_lz_nxt;
  l2l10_pkg::in_class_t        cls_nxt;

  // normalize stage results
  logic        [23:0] frac_nxt;
  logic signed [8:0]  e_nxt;

  // carried payload
  l2l10_pkg::in_class_t        cls_pipe_r  [0:NS-1];
  logic                 [23:0] frac_pipe_r [1:5];
  logic signed          [8:0]  e_pipe_r    [1:6];

  // horner and scaling datapath
  logic signed [P_W-1:0]  p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic signed [Y_W-1:0]  y1_r, y1_nxt, y2_r, y2_nxt;
  logic signed [Y3_W-1:0] y3_r, y3_nxt;
  logic signed [W_W-1:0]  wide_r, wide_nxt;
  logic signed [OW-1:0]   res_r, res_nxt;

  // rounding temporaries
  logic signed [P_W-1:0] rnd1, rnd2, rnd3;
  logic signed [W_W-1:0] rsum;

  // stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[NS-1] = ~v_r[NS-1] | ~out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = ~v_r[i] | en[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < NS; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  assign in_stall  = ~en[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r           <= '0;
      base_select_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
      if (cfg_wr_en) begin
        base_select_r <= cfg_wr_data;
      end
    end
  end

  // classify and count leading zeros of the mantissa
  always_comb begin
    d_lz_nxt = l2l10_pkg::lead_zeros(in_float_bits[22:0]);
    if (in_float_bits[30:23] == 8'hFF) begin
      cls_nxt = l2l10_pkg::CLS_SPECIAL;
    end else if (in_float_bits[30:0] == 31'd0) begin
      cls_nxt = l2l10_pkg::CLS_ZERO;
    end else begin
      cls_nxt = l2l10_pkg::CLS_NORMAL;
    end
  end

  // normalize: zero maps to F = 0 and E = 0 so the polynomial gives C0
  always_comb begin
    if (d_expf_r != 8'd0) begin
      frac_nxt = {1'b1, d_mant_r};
      e_nxt    = $signed({1'b0, d_expf_r}) - 9'sd126;
    end else if (d_mant_r == 23'd0) begin
      frac_nxt = 24'd0;
      e_nxt    = 9'sd0;
    end else begin
      frac_nxt = {d_mant_r, 1'b0} << d_lz_r;
      e_nxt    = -9'sd126 - $signed({4'd0, d_lz_r});
    end
  end

  // horner steps: multiply, then round and add the next coefficient
  always_comb begin
    p1_nxt = P_W'(C3_Y) * P_W'($signed({1'b0, frac_pipe_r[1]}));
    rnd1   = (p1_r + P_HALF) >>> l2l10_pkg::Q;
    y1_nxt = $signed(rnd1[Y_W-1:0]) + C2_Y;
    p2_nxt = P_W'(y1_r) * P_W'($signed({1'b0, frac_pipe_r[3]}));
    rnd2   = (p2_r + P_HALF) >>> l2l10_pkg::Q;
    y2_nxt = $signed(rnd2[Y_W-1:0]) + C1_Y;
    p3_nxt = P_W'(y2_r) * P_W'($signed({1'b0, frac_pipe_r[5]}));
    rnd3   = (p3_r + P_HALF) >>> l2l10_pkg::Q;
    y3_nxt = $signed(rnd3[Y3_W-1:0]) + Y3_W'(C0_Y)
           + (Y3_W'(e_pipe_r[6]) <<< l2l10_pkg::Q);
  end

  // scaling to 54 fraction bits, log10 mode multiplies by log10(2)
  always_comb begin
    if (base_select_r) begin
      wide_nxt = W_W'(y3_r) * W_W'(L10_S);
    end else begin
      wide_nxt = W_W'(y3_r) <<< 30;
    end
  end

  // final rounding, saturation and special-value override
  always_comb begin
    rsum = (wide_r + W_HALF) >>> SH;
    if (cls_pipe_r[NS-2] == l2l10_pkg::CLS_SPECIAL) begin
      res_nxt = '0;
    end else if (rsum > OUT_MAX) begin
      res_nxt = OUT_MAX[OW-1:0];
    end else if (rsum < OUT_MIN) begin
      res_nxt = OUT_MIN[OW-1:0];
    end else begin
      res_nxt = rsum[OW-1:0];
    end
  end

  // payload registers, loaded with their stage enable
  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_expf_r      <= in_float_bits[30:23];
      d_mant_r      <= in_float_bits[22:0];
      d_lz_r        <= d_lz_nxt;
      cls_pipe_r[0] <= cls_nxt;
    end
    for (int i = 1; i < NS; i++) begin
      if (en[i]) begin
        cls_pipe_r[i] <= cls_pipe_r[i-1];
      end
    end
    if (en[1]) begin
      frac_pipe_r[1] <= frac_nxt;
      e_pipe_r[1]    <= e_nxt;
    end
    for (int i = 2; i <= 5; i++) begin
      if (en[i]) begin
        frac_pipe_r[i] <= frac_pipe_r[i-1];
      end
    end
    for (int i = 2; i <= 6; i++) begin
      if (en[i]) begin
        e_pipe_r[i] <= e_pipe_r[i-1];
      end
    end
    if (en[2]) begin
      p1_r <= p1_nxt;
    end
    if (en[3]) begin
      y1_r <= y1_nxt;
    end
    if (en[4]) begin
      p2_r <= p2_nxt;
    end
    if (en[5]) begin
      y2_r <= y2_nxt;
    end
    if (en[6]) begin
      p3_r <= p3_nxt;
    end
    if (en[7]) begin
      y3_r <= y3_nxt;
    end
    if (en[8]) begin
      wide_r <= wide_nxt;
    end
    if (en[9]) begin
      res_r <= res_nxt;
    end
  end

  assign out_log_value   = res_r;
  assign out_input_class = cls_pipe_r[NS-1];

endmodule

[src/l2l10_chk.sv]
// port-level checker for the log2/log10 approximation, bound to the top level
`include "log2_log10_cubic_approx_assert.svh"

module l2l10_chk (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [l2l10_pkg::OUT_WIDTH-1:0] out_log_value,
  input logic [1:0]                             out_input_class
);

  // a stalled result holds
  `L2L10_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_log_value) && $stable(out_input_class), "stalled result changed")

  // input backs up only when the whole pipeline is full and blocked
  `L2L10_ASSERT_IMP(a_in_stall_full, in_stall, out_valid && out_stall, "input stalled with room in pipeline")

  // infinity or nan always reports zero
  `L2L10_ASSERT_IMP(a_special_zero, out_valid && (out_input_class == l2l10_pkg::CLS_SPECIAL), out_log_value == '0, "special input gave nonzero value")

  // reset empties the pipeline
  `L2L10_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result valid after reset")

endmodule

bind log2_log10_cubic_approx l2l10_chk u_l2l10_chk (.*);
